[src/bcc_pkg.sv]
// shared types and constants for the button click classifier
package bcc_pkg;

  // age counter width; ages saturate at all ones
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CFG_BITS   = 16;
  localparam int unsigned CMP_BITS   = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

  // configuration port
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE     = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_DOUBLE_CLICK = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS   = CFG_IDX_BITS'(2);

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RST     = CFG_BITS'(50);
  localparam logic [CFG_BITS-1:0] DOUBLE_CLICK_RST = CFG_BITS'(500);
  localparam logic [CFG_BITS-1:0] LONG_PRESS_RST   = CFG_BITS'(2000);

  // stream data widths
  localparam int unsigned S_DATA_BITS = 8;
  localparam int unsigned M_DATA_BITS = 8;

  typedef logic [COUNT_BITS-1:0] age_t;

  localparam age_t AGE_MAX = {COUNT_BITS{1'b1}};

  // gesture codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  // timing thresholds handed to the classifier core
  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ms;
    logic [CFG_BITS-1:0] double_click_ms;
    logic [CFG_BITS-1:0] long_press_ms;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic   held;
    event_e event_res;
  } result_t;

endpackage

[src/button_click_classifier.sv]
// top level of the button click classifier
//
// Usage: one active-low button sample per millisecond tick enters on the
// slave stream (s_axis_*); bit 0 of tdata is the pin level. Each accepted
// sample yields exactly one result on the master stream (m_axis_*): the
// gesture found on that tick (none, single, double, long) and the held flag.
// Thresholds are set through the write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i): index 0 debounce, 1 double-click window, 2 long-press time,
// all in ticks; other indexes are ignored. Write only while idle.
// The result is registered and appears in the cycle after the sample transfer.
// Throughput: one sample per cycle while the output is drained; the classifier
// state update is a single pass of counter increments and compares between
// the state registers and the output register.
// Reset: thresholds return to 50 / 500 / 2000, the pin is taken as released,
// both ages restart from zero and no result is pending.
// Stall: the output register holds its result while m_axis_tready_i is low;
// s_axis_tready_o drops only while that register is full and not drained.
module button_click_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // slave stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [bcc_pkg::S_DATA_BITS-1:0]     s_axis_tdata_i,  // [0] raw_level
  // master stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [bcc_pkg::M_DATA_BITS-1:0]     m_axis_tdata_o,  // [1:0] event_res, [2] held
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [bcc_pkg::CFG_BITS-1:0]        cfg_wdata_i
);

  bcc_pkg::cfg_t    cfg;
  bcc_pkg::result_t res;
  bcc_pkg::result_t res_q;
  logic             out_valid_q, out_valid_d;
  logic             in_xfer;

  bcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // accept whenever the output register is empty or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  bcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_xfer),
    .raw_level_i (s_axis_tdata_i[0]),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  // output register valid tracking
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded on each input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, res_q.held, res_q.event_res};

endmodule

[src/bcc_cfg_regs.sv]
// configuration register bank for the button click classifier
module bcc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bcc_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [bcc_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  output bcc_pkg::cfg_t                       cfg_o
);

  bcc_pkg::cfg_t cfg_q, cfg_d;

  // register decode, unknown index is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcc_pkg::REG_DEBOUNCE:     cfg_d.debounce_ms     = cfg_wdata_i;
        bcc_pkg::REG_DOUBLE_CLICK: cfg_d.double_click_ms = cfg_wdata_i;
        bcc_pkg::REG_LONG_PRESS:   cfg_d.long_press_ms   = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= bcc_pkg::DEBOUNCE_RST;
      cfg_q.double_click_ms <= bcc_pkg::DOUBLE_CLICK_RST;
      cfg_q.long_press_ms   <= bcc_pkg::LONG_PRESS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[src/bcc_core.sv]
// gesture state and per-tick next-state logic
module bcc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               raw_level_i,
  input  bcc_pkg::cfg_t      cfg_i,
  output bcc_pkg::result_t   res_o
);

  logic              last_level_q, last_level_d;
  logic              pressed_q, pressed_d;
  logic              waiting_q, waiting_d;
  logic              long_fired_q, long_fired_d;
  bcc_pkg::age_t     press_age_q, press_age_d;
  bcc_pkg::age_t     release_age_q, release_age_d;

  logic [bcc_pkg::CMP_BITS-1:0] press_cmp, release_cmp;
  logic [bcc_pkg::CMP_BITS-1:0] deb_cmp, dbl_cmp, long_cmp;
  bcc_pkg::event_e   ev;

  // widen thresholds and ages to a common compare width
  assign deb_cmp  = bcc_pkg::CMP_BITS'(cfg_i.debounce_ms);
  assign dbl_cmp  = bcc_pkg::CMP_BITS'(cfg_i.double_click_ms);
  assign long_cmp = bcc_pkg::CMP_BITS'(cfg_i.long_press_ms);

  always_comb begin
    // saturating age update
    press_age_d   = (press_age_q == bcc_pkg::AGE_MAX) ? press_age_q
                                                      : press_age_q + 1'b1;
    release_age_d = (release_age_q == bcc_pkg::AGE_MAX) ? release_age_q
                                                        : release_age_q + 1'b1;
    pressed_d    = pressed_q;
    waiting_d    = waiting_q;
    long_fired_d = long_fired_q;
    last_level_d = raw_level_i;
    ev           = bcc_pkg::EV_NONE;

    release_cmp = bcc_pkg::CMP_BITS'(release_age_d);
    press_cmp   = bcc_pkg::CMP_BITS'(press_age_d);

    // edge handling
    if (last_level_q && !raw_level_i) begin
      if (release_cmp >= deb_cmp) begin
        pressed_d    = 1'b1;
        press_age_d  = '0;
        long_fired_d = 1'b0;
        if (waiting_q) begin
          waiting_d = 1'b0;
          ev        = bcc_pkg::EV_DOUBLE;
        end
      end
    end else if (!last_level_q && raw_level_i) begin
      pressed_d = 1'b0;
      if (!long_fired_q && (press_cmp < long_cmp)) begin
        waiting_d = 1'b1;
      end
      release_age_d = '0;
    end

    // timer checks on the post-edge state
    press_cmp   = bcc_pkg::CMP_BITS'(press_age_d);
    release_cmp = bcc_pkg::CMP_BITS'(release_age_d);
    if (pressed_d && !long_fired_d && (press_cmp >= long_cmp)) begin
      long_fired_d = 1'b1;
      ev           = bcc_pkg::EV_LONG;
    end
    if (waiting_d && (release_cmp >= dbl_cmp)) begin
      waiting_d = 1'b0;
      ev        = bcc_pkg::EV_SINGLE;
    end
  end

  // state advances once per accepted sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q  <= 1'b1;
      pressed_q     <= 1'b0;
      waiting_q     <= 1'b0;
      long_fired_q  <= 1'b0;
      press_age_q   <= '0;
      release_age_q <= '0;
    end else if (step_i) begin
      last_level_q  <= last_level_d;
      pressed_q     <= pressed_d;
      waiting_q     <= waiting_d;
      long_fired_q  <= long_fired_d;
      press_age_q   <= press_age_d;
      release_age_q <= release_age_d;
    end
  end

  assign res_o.held      = pressed_d;
  assign res_o.event_res = ev;

endmodule

[dv/bcc_gesture_checker.sv]
// gesture checker: mirrors the classifier per accepted sample and scores its results
`timescale 1ns / 100ps

module bcc_gesture_checker
  import bcc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_tvalid_i,
  input  logic                    s_tready_i,
  input  logic [S_DATA_BITS-1:0]  s_tdata_i,   // [0] raw_level
  input  logic                    m_tvalid_i,
  input  logic                    m_tready_i,
  input  logic [M_DATA_BITS-1:0]  m_tdata_i,   // [1:0] event_res, [2] held
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o,
  output int unsigned             singles_o,
  output int unsigned             doubles_o,
  output int unsigned             longs_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  // mirrored thresholds
  logic [CFG_BITS-1:0] debounce_ms;
  logic [CFG_BITS-1:0] window_ms;
  logic [CFG_BITS-1:0] hold_ms;

  // mirrored classifier state
  logic    pin_was_high;
  logic    press_active;
  logic    window_open;
  logic    long_reported;
  age_t    press_age;
  age_t    release_age;

  // results still owed by the block, oldest first
  result_t gesture_q[$];
  result_t want;
  result_t got;

  function automatic age_t age_inc(age_t a);
    return (a == AGE_MAX) ? AGE_MAX : a + age_t'(1);
  endfunction

  // one tick of the gesture classifier
  task automatic classify_tick(input logic level, output result_t r);
    event_e ev;
    ev          = EV_NONE;
    press_age   = age_inc(press_age);
    release_age = age_inc(release_age);

    // edge handling: press needs the debounce time since the last release
    if (pin_was_high && !level) begin
      if (release_age >= debounce_ms) begin
        press_active  = 1'b1;
        press_age     = '0;
        long_reported = 1'b0;
        if (window_open) begin
          window_open = 1'b0;
          ev          = EV_DOUBLE;
        end
      end
    end else if (!pin_was_high && level) begin
      press_active = 1'b0;
      if (!long_reported && press_age < hold_ms) window_open = 1'b1;
      release_age = '0;
    end
    pin_was_high = level;

    // timers, checked against the post-edge state
    if (press_active && !long_reported && press_age >= hold_ms) begin
      long_reported = 1'b1;
      ev            = EV_LONG;
    end
    if (window_open && release_age >= window_ms) begin
      window_open = 1'b0;
      ev          = EV_SINGLE;
    end

    r.event_res = ev;
    r.held      = press_active;
  endtask

  // watch both streams and the write port
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms   = DEBOUNCE_RST;
      window_ms     = DOUBLE_CLICK_RST;
      hold_ms       = LONG_PRESS_RST;
      pin_was_high  = 1'b1;
      press_active  = 1'b0;
      window_open   = 1'b0;
      long_reported = 1'b0;
      press_age     = '0;
      release_age   = '0;
      gesture_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      singles_o     = 0;
      doubles_o     = 0;
      longs_o       = 0;
    end else begin
      // result transfer: compare with the oldest owed result
      if (m_tvalid_i && m_tready_i) begin
        got.event_res = event_e'(m_tdata_i[1:0]);
        got.held      = m_tdata_i[2];
        if (gesture_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT)
            $display("%0t: result with none owed: event %0d held %0b",
                     $realtime, got.event_res, got.held);
        end else begin
          want = gesture_q.pop_front();
          if (want.event_res != got.event_res || want.held != got.held) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT)
              $display("%0t: mismatch: expected event %s held %0b, got event %0d held %0b",
                       $realtime, want.event_res.name(), want.held,
                       got.event_res, got.held);
          end
        end
      end

      // sample transfer: predict its result
      if (s_tvalid_i && s_tready_i) begin
        classify_tick(s_tdata_i[0], want);
        gesture_q.push_back(want);
        case (want.event_res)
          EV_SINGLE: singles_o++;
          EV_DOUBLE: doubles_o++;
          EV_LONG:   longs_o++;
          default: ;
        endcase
      end

      // threshold writes; unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEBOUNCE:     debounce_ms = cfg_wdata_i;
          REG_DOUBLE_CLICK: window_ms   = cfg_wdata_i;
          REG_LONG_PRESS:   hold_ms     = cfg_wdata_i;
          default: ;
        endcase
      end

      pending_o = gesture_q.size();
    end
  end

endmodule

[dv/tb_button_click_classifier.sv]
// testbench top for the button click classifier: stimulus, handshakes and verdict
`timescale 1ns / 100ps

module tb_button_click_classifier;
  import bcc_pkg::*;

  localparam int unsigned SAMPLE_TARGET  = 1850;
  localparam int unsigned PHASE_SAMPLES  = 150;
  localparam int unsigned MAX_WAIT       = 6;
  localparam int unsigned SPAN_CAP       = 24;
  localparam int unsigned DRAIN_TICKS    = 4;
  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(3);

  // block inputs, all known from time zero
  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic [S_DATA_BITS-1:0]  s_axis_tdata_i  = '0;
  logic                    m_axis_tready_i = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i       = '0;
  logic [CFG_BITS-1:0]     cfg_wdata_i     = '0;

  logic                    s_axis_tready_o;
  logic                    m_axis_tvalid_o;
  logic [M_DATA_BITS-1:0]  m_axis_tdata_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned singles;
  int unsigned doubles;
  int unsigned longs;

  // stimulus bookkeeping
  bit                  steady;
  int unsigned         samples_sent;
  int unsigned         settings_done;
  logic [CFG_BITS-1:0] cur_debounce;
  logic [CFG_BITS-1:0] cur_window;
  logic [CFG_BITS-1:0] cur_hold;

  always #5 clk_i = ~clk_i;

  button_click_classifier u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  bcc_gesture_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_i   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .m_tvalid_i   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_i    (m_axis_tdata_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .singles_o    (singles),
    .doubles_o    (doubles),
    .longs_o      (longs)
  );

  // one pin sample, after a random gap; returns at the falling edge after the transfer
  task automatic send_level(input logic lvl);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(S_DATA_BITS-1){1'b0}}, lvl};
    do @(posedge clk_i); while (!s_axis_tready_o);
    samples_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_level(input logic lvl, input int unsigned ticks);
    repeat (ticks) send_level(lvl);
  endtask

  // stop sending and wait until every owed result has come out
  task automatic go_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_TICKS) @(negedge clk_i);
  endtask

  // write all thresholds while idle, plus one write to the unused index
  task automatic apply_settings(input logic [CFG_BITS-1:0] db,
                                input logic [CFG_BITS-1:0] win,
                                input logic [CFG_BITS-1:0] hold);
    go_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DEBOUNCE;
    cfg_wdata_i <= db;
    @(negedge clk_i);
    cfg_idx_i   <= REG_DOUBLE_CLICK;
    cfg_wdata_i <= win;
    @(negedge clk_i);
    cfg_idx_i   <= REG_LONG_PRESS;
    cfg_wdata_i <= hold;
    @(negedge clk_i);
    cfg_idx_i   <= REG_SPARE;
    cfg_wdata_i <= CFG_BITS'($urandom_range(0, 16'hFFFF));
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    cur_debounce  = db;
    cur_window    = win;
    cur_hold      = hold;
    settings_done++;
  endtask

  // result side: random stalls between transfers
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  // watchdog: too long without any transfer ends the run
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog expired with %0d results owed", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned         phase;
    int unsigned         phase_end;
    int unsigned         hold_span;
    int unsigned         gap_span;
    logic [CFG_BITS-1:0] db;
    logic [CFG_BITS-1:0] win;
    logic [CFG_BITS-1:0] hold;

    steady        = 1'b0;
    samples_sent  = 0;
    settings_done = 0;
    cur_debounce  = DEBOUNCE_RST;
    cur_window    = DOUBLE_CLICK_RST;
    cur_hold      = LONG_PRESS_RST;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset thresholds: press right after boot is debounced away,
    // its release still opens the click window
    run_level(1'b1, 2);
    run_level(1'b0, 2);
    run_level(1'b1, 2);

    // short thresholds: single click, double click on the window deadline,
    // long press after the second press, release after the long press
    apply_settings(CFG_BITS'(2), CFG_BITS'(3), CFG_BITS'(4));
    run_level(1'b1, 3);
    run_level(1'b0, 2);
    run_level(1'b1, 4);
    run_level(1'b0, 2);
    run_level(1'b1, 3);
    run_level(1'b0, 5);
    run_level(1'b1, 1);

    // random gestures under a series of threshold settings
    phase = 0;
    while (samples_sent < SAMPLE_TARGET) begin
      case (phase)
        0: begin db = '0;           win = CFG_BITS'(1); hold = CFG_BITS'(1); end
        1: begin db = '1;           win = '1;           hold = '1;           end
        2: begin db = '0;           win = '1;           hold = CFG_BITS'(1); end
        3: begin db = CFG_BITS'(1); win = CFG_BITS'(1); hold = '1;           end
        default: begin
          db   = CFG_BITS'($urandom_range(0, 6));
          win  = CFG_BITS'($urandom_range(1, 10));
          hold = CFG_BITS'($urandom_range(1, 15));
        end
      endcase
      apply_settings(db, win, hold);
      hold_span = (cur_hold > SPAN_CAP) ? SPAN_CAP : cur_hold;
      gap_span  = ((cur_debounce > SPAN_CAP) ? SPAN_CAP : cur_debounce) +
                  ((cur_window > SPAN_CAP) ? SPAN_CAP : cur_window);
      phase_end = samples_sent + PHASE_SAMPLES;
      // last phase stops near the sample target
      if (phase_end > SAMPLE_TARGET) phase_end = SAMPLE_TARGET;
      while (samples_sent < phase_end) begin
        steady = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 6) == 0) begin
          // bouncing pin
          repeat ($urandom_range(1, 6)) send_level(1'($urandom_range(0, 1)));
        end else begin
          // press then release, lengths around the thresholds
          run_level(1'b0, $urandom_range(1, hold_span + 2));
          run_level(1'b1, $urandom_range(1, gap_span + 2));
        end
      end
      steady = 1'b0;
      phase++;
    end

    go_idle();
    $display("run covered %0d pin samples under %0d threshold settings, extremes included",
             samples_sent, settings_done);
    $display("gestures checked: %0d single, %0d double, %0d long; %0d mismatches",
             singles, doubles, longs, fail_count);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[button_click_classifier.f]
src/bcc_pkg.sv
src/bcc_cfg_regs.sv
src/bcc_core.sv
src/button_click_classifier.sv
dv/bcc_gesture_checker.sv
dv/tb_button_click_classifier.sv
